// ===== src/cbq_pkg.sv =====
// Shared types and fixed-point constants for the cascaded biquad filter.
// No dependencies; used by cascaded_biquad_filter and cbq_checker.
package cbq_pkg;

    // Number formats
    localparam int SAMPLE_W = 24;                  // signed sample width
    localparam int COEF_W   = 32;                  // signed Q3.29 coefficient width
    localparam int FRAC_W   = COEF_W - 3;          // coefficient fraction bits
    localparam int PROD_W   = SAMPLE_W + COEF_W;   // one product
    localparam int ACC_W    = PROD_W + 4;          // five products plus rounding

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_FILTER = 2'd0,
        ACT_COEF   = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    // Coefficient slots within one section
    localparam logic [2:0] COEF_B0  = 3'd0;
    localparam logic [2:0] COEF_B1  = 3'd1;
    localparam logic [2:0] COEF_B2  = 3'd2;
    localparam logic [2:0] COEF_A1  = 3'd3;
    localparam logic [2:0] COEF_A2  = 3'd4;
    localparam int         NUM_COEF = 5;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_TAIL1,
        S_TAIL2
    } t_state;

endpackage

// ===== src/cascaded_biquad_filter.sv =====
// Cascaded direct-form-I biquad filter with one shared multiply-accumulate unit.
// Depends on cbq_pkg; coefficient and history stores are local synchronous memories.
//
//  channel   dir  signals                              request carries
//  -------   ---  -----------------------------------  --------------------------------
//  s_*       in   s_tvalid s_tready s_tdata s_tuser    sample / coefficient / clear
//  m_*       out  m_tvalid m_tready m_tdata m_tuser    filtered sample and overflow flag
//  cfg       in   i_cfg_valid o_cfg_ready i_cfg_data   active section count
//
//  A sample request steps through each active section in turn, one product per cycle on
//  the shared multiplier; each section waits out the memory read, multiply and accumulate
//  registers before its output feeds the next section. Coefficient and clear requests
//  do not make the unit busy.
//  i_rst_n is synchronous, active low: one section in use, coefficients and history
//  read as zero through per-entry valid bits. A stalled result waits in the output
//  register; the next request is accepted meanwhile and stalls only at its own end.
module cascaded_biquad_filter #(
    parameter int MAX_SECTIONS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_in[23:0], section_index[26:24],
                                   // coef_index[29:27], coef_value[61:30], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // sample_out[23:0]
    output logic [0:0]  m_tuser,   // overflow[0]
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data // active_sections[3:0]
);

    localparam int NCOEF = cbq_pkg::NUM_COEF * MAX_SECTIONS;
    localparam int NHIST = 2 * (MAX_SECTIONS + 1);
    localparam int CA_W  = $clog2(NCOEF);
    localparam int HA_W  = $clog2(NHIST);
    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int SW    = cbq_pkg::SAMPLE_W;
    localparam int CW    = cbq_pkg::COEF_W;
    localparam int PW    = cbq_pkg::PROD_W;
    localparam int AW    = cbq_pkg::ACC_W;
    localparam int FW    = cbq_pkg::FRAC_W;

    // Request fields
    logic signed [SW-1:0] in_sample;
    logic [2:0]           in_sec;
    logic [2:0]           in_ci;
    logic signed [CW-1:0] in_coef;
    assign in_sample = s_tdata[23:0];
    assign in_sec    = s_tdata[26:24];
    assign in_ci     = s_tdata[29:27];
    assign in_coef   = s_tdata[61:30];

    // Control registers
    cbq_pkg::t_state r_state, n_state;
    logic [3:0]       r_active;
    logic [2:0]       r_ph;        // phase within one section, 0..7
    logic [SEC_W-1:0] r_sec;       // section being computed
    logic [SEC_W-1:0] r_last;      // last active section of this sample
    logic [CA_W-1:0]  r_cbase;     // 5 * section
    logic [HA_W-1:0]  r_hbase;     // 2 * section
    logic             r_out_vld;
    logic [NCOEF-1:0] r_coef_vld;
    logic [NHIST-1:0] r_hist_vld;

    // Datapath registers
    logic signed [SW-1:0] r_x;     // current stage input, then its output
    logic                 r_ovf;
    logic signed [SW-1:0] r_d0;    // old newest input of the current pair
    logic signed [SW-1:0] r_d2;    // old newest input of the next pair
    logic signed [PW-1:0] r_prod;
    logic                 r_prod_sub;
    logic signed [AW-1:0] r_acc;
    logic signed [SW-1:0] r_out_data;
    logic                 r_out_ovf;

    // Memories
    logic signed [CW-1:0] r_coef_mem [NCOEF];
    logic signed [SW-1:0] r_hist_mem [NHIST];
    logic signed [CW-1:0] r_coef_q;
    logic signed [SW-1:0] r_hist_q;

    // Combinational controls
    logic             accept;
    logic             out_free;
    logic             coef_we;
    logic [CA_W-1:0]  coef_wa;
    logic [CA_W-1:0]  coef_ra;
    logic [HA_W-1:0]  hist_ra;
    logic             hist_we;
    logic [HA_W-1:0]  hist_wa;
    logic signed [SW-1:0] hist_wd;
    logic             load_out;
    logic [SEC_W-1:0] last_sec;

    assign accept      = s_tvalid && s_tready;
    assign out_free    = !r_out_vld || m_tready;
    assign o_cfg_ready = (r_state == cbq_pkg::S_IDLE);

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_ovf;

    // Clamp the section count into 1..MAX_SECTIONS
    always_comb begin
        int n_sec;
        n_sec = int'(r_active);
        if (n_sec == 0) begin
            n_sec = 1;
        end
        if (n_sec > MAX_SECTIONS) begin
            n_sec = MAX_SECTIONS;
        end
        last_sec = SEC_W'(n_sec - 1);
    end

    // Coefficient write: ignore out-of-range section or slot
    assign coef_we = accept && (s_tuser == cbq_pkg::ACT_COEF)
                     && (int'(in_sec) < MAX_SECTIONS) && (int'(in_ci) < cbq_pkg::NUM_COEF);
    assign coef_wa = CA_W'(int'(in_sec) * cbq_pkg::NUM_COEF + int'(in_ci));

    // Read issue per phase: b1*d0, b2*d1, a1*d2, a2*d3, then b0*x
    always_comb begin
        logic [2:0] c_off;
        logic [1:0] h_off;
        case (r_ph)
            3'd0: begin
                c_off = cbq_pkg::COEF_B1;
                h_off = 2'd0;
            end
            3'd1: begin
                c_off = cbq_pkg::COEF_B2;
                h_off = 2'd1;
            end
            3'd2: begin
                c_off = cbq_pkg::COEF_A1;
                h_off = 2'd2;
            end
            3'd3: begin
                c_off = cbq_pkg::COEF_A2;
                h_off = 2'd3;
            end
            default: begin
                c_off = cbq_pkg::COEF_B0;
                h_off = 2'd0;
            end
        endcase
        coef_ra = r_cbase + CA_W'(c_off);
        hist_ra = r_hbase + HA_W'(h_off);
    end

    // Round to nearest (halves up), drop fraction bits, saturate
    logic signed [AW-1:0] rnd;
    logic [AW-FW-SW:0]    rnd_top;
    logic signed [SW-1:0] stage_y;
    logic                 stage_sat;
    always_comb begin
        rnd       = r_acc + cbq_pkg::ACC_HALF;
        rnd_top   = rnd[AW-1:FW+SW-1];
        stage_sat = !((&rnd_top) || !(|rnd_top));
        if (!stage_sat) begin
            stage_y = rnd[FW+SW-1:FW];
        end else if (rnd[AW-1]) begin
            stage_y = cbq_pkg::SAMPLE_MIN;
        end else begin
            stage_y = cbq_pkg::SAMPLE_MAX;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, history write-back and handshake
    always_comb begin
        n_state  = r_state;
        s_tready = 1'b0;
        hist_we  = 1'b0;
        hist_wa  = r_hbase;
        hist_wd  = r_x;
        load_out = 1'b0;
        case (r_state)
            cbq_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == cbq_pkg::ACT_FILTER) begin
                    n_state = cbq_pkg::S_RUN;
                end
            end
            cbq_pkg::S_RUN: begin
                // shift the pair of this section: d1 <= old d0, d0 <= stage input
                if (r_ph == 3'd6) begin
                    hist_we = 1'b1;
                    hist_wa = r_hbase + HA_W'(1);
                    hist_wd = r_d0;
                end else if (r_ph == 3'd7) begin
                    hist_we = 1'b1;
                    if (r_sec == r_last) begin
                        n_state = cbq_pkg::S_TAIL1;
                    end
                end
            end
            cbq_pkg::S_TAIL1: begin
                // output pair of the last section: d1 <= old d0
                hist_we = 1'b1;
                hist_wa = r_hbase + HA_W'(1);
                hist_wd = r_d2;
                n_state = cbq_pkg::S_TAIL2;
            end
            cbq_pkg::S_TAIL2: begin
                // hold here until the output register can take the result
                if (out_free) begin
                    hist_we  = 1'b1;
                    load_out = 1'b1;
                    n_state  = cbq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cbq_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer counters, configuration, output valid, store valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 4'd1;
            r_ph       <= '0;
            r_sec      <= '0;
            r_last     <= '0;
            r_cbase    <= '0;
            r_hbase    <= '0;
            r_out_vld  <= 1'b0;
            r_coef_vld <= '0;
            r_hist_vld <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            if (accept && s_tuser == cbq_pkg::ACT_FILTER) begin
                r_ph    <= '0;
                r_sec   <= '0;
                r_last  <= last_sec;
                r_cbase <= '0;
                r_hbase <= '0;
            end else if (r_state == cbq_pkg::S_RUN) begin
                r_ph <= r_ph + 3'd1;
                if (r_ph == 3'd7) begin
                    r_sec   <= r_sec + SEC_W'(1);
                    r_cbase <= r_cbase + CA_W'(cbq_pkg::NUM_COEF);
                    r_hbase <= r_hbase + HA_W'(2);
                end
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (coef_we) begin
                r_coef_vld[coef_wa] <= 1'b1;
            end
            if (accept && s_tuser == cbq_pkg::ACT_CLEAR) begin
                r_hist_vld <= '0;
            end else if (hist_we) begin
                r_hist_vld[hist_wa] <= 1'b1;
            end
        end
    end

    // Coefficient memory: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[coef_wa] <= in_coef;
        end
        r_coef_q <= r_coef_vld[coef_ra] ? r_coef_mem[coef_ra] : '0;
    end

    // History memory: entries are zero until written after reset or a clear
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[hist_wa] <= hist_wd;
        end
        r_hist_q <= r_hist_vld[hist_ra] ? r_hist_mem[hist_ra] : '0;
    end

    // Multiply-accumulate pipeline: read data at phases 1..5, products at 2..6
    always_ff @(posedge i_clk) begin
        if (accept && s_tuser == cbq_pkg::ACT_FILTER) begin
            r_x   <= in_sample;
            r_ovf <= 1'b0;
        end else if (r_state == cbq_pkg::S_RUN && r_ph == 3'd7) begin
            r_x   <= stage_y;
            r_ovf <= r_ovf | stage_sat;
        end
        if (r_ph == 3'd1) begin
            r_d0 <= r_hist_q;
        end
        if (r_ph == 3'd3) begin
            r_d2 <= r_hist_q;
        end
        r_prod     <= ((r_ph == 3'd5) ? r_x : r_hist_q) * r_coef_q;
        r_prod_sub <= (r_ph == 3'd3) || (r_ph == 3'd4);
        if (r_ph == 3'd1) begin
            r_acc <= '0;
        end else if (r_ph inside {[3'd2:3'd6]}) begin
            if (r_prod_sub) begin
                r_acc <= r_acc - {{(AW-PW){r_prod[PW-1]}}, r_prod};
            end else begin
                r_acc <= r_acc + {{(AW-PW){r_prod[PW-1]}}, r_prod};
            end
        end
        if (load_out) begin
            r_out_data <= r_x;
            r_out_ovf  <= r_ovf;
        end
    end

endmodule

// ===== src/cbq_checker.sv =====
// Port-level checks for cascaded_biquad_filter, bound to every instance.
// Depends on cbq_pkg for the request kinds.
module cbq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a filter request makes the unit busy: ready drops after it
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser == cbq_pkg::ACT_FILTER |=> !s_tready)
        else $error("ready stayed high after a filter request");

    // coefficient and clear requests leave ready high
    a_ctrl_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser != cbq_pkg::ACT_FILTER |=> s_tready)
        else $error("ready dropped after a control request");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind cascaded_biquad_filter cbq_checker u_cbq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
